[rtl/sks_pkg.sv]
// sks_pkg: types, constants and register indexes of the solenoid kick/sustain controller.
// No dependencies; used by the top level, sks_update and the testbench.
package sks_pkg;

    localparam int NUM_SOLENOIDS = 8;
    localparam int SOL_IDX_W     = (NUM_SOLENOIDS > 1) ? $clog2(NUM_SOLENOIDS) : 1;
    localparam int NUM_PORT_SOL  = 8;

    localparam logic [7:0]  OFF_STEP       = 8'h10;
    localparam int          PWM_PERIOD_MS  = 16;
    localparam int          US_PER_MS      = 1000;
    localparam logic [31:0] SUSTAIN_END_US = 32'((PWM_PERIOD_MS + 1) * US_PER_MS);

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_ENABLE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_USE_SWITCH_MASK  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_AUTO_CLEAR_MASK  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KICK_TIMES_MS    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DUTY_SETTINGS    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SWITCH_THRESH_US = 3'd5;

    // solenoid -> switch port bit
    localparam logic [2:0] PORT_BIT_OF [NUM_PORT_SOL] = '{
        3'd0, 3'd1, 3'd3, 3'd2, 3'd5, 3'd4, 3'd7, 3'd6
    };

    typedef enum logic [2:0] {
        PH_IDLE       = 3'd0,
        PH_DEBOUNCE   = 3'd1,
        PH_KICK       = 3'd2,
        PH_SUSTAIN    = 3'd3,
        PH_WAIT_CLEAR = 3'd4,
        PH_MIN_OFF    = 3'd5
    } sks_phase_t;

    typedef struct packed {
        sks_phase_t  phase;
        logic [31:0] start_us;
        logic [7:0]  off_count;
        logic        found_clear;
    } sks_entry_t;

    localparam int ENTRY_W = $bits(sks_entry_t);

    typedef struct packed {
        logic        act;
        logic [7:0]  kick_ms;
        logic [3:0]  duty;
        logic [7:0]  off_limit;
        logic        auto_clear;
    } sks_ctl_t;

    typedef struct packed {
        logic drive_set;
        logic drive_clr;
        logic validated;
        logic clear_req;
    } sks_flags_t;

    typedef struct packed {
        logic [31:0] time_us;
        logic [7:0]  switch_levels;
        logic [7:0]  proc_request;
    } sks_in_t;

    typedef struct packed {
        logic [7:0] drive_bits;
        logic [7:0] valid_switch_set;
        logic [7:0] request_clear;
    } sks_out_t;

endpackage

[rtl/solenoid_kick_sustain_controller.sv]
// solenoid_kick_sustain_controller: top level; poll sequencer, config registers,
// drive register and result register. Depends on sks_pkg, sks_ram, sks_update.
//
//   channel  dir  handshake            payload
//   s_       in   s_valid / s_ready    s_data  (sks_in_t: time_us, switch_levels, proc_request)
//   m_       out  m_valid / m_ready    m_data  (sks_out_t: drive_bits, valid_switch_set,
//                                               request_clear)
//   cfg_     in   cfg_wr_en            cfg_index, cfg_wdata
//
// A request walks all NUM_SOLENOIDS (8) solenoid entries, one per cycle except for a stall at
// the last one, through the state RAM's read and write ports.
// A new request is taken in the last cycle of the previous one, so requests run back to back.
// Synchronous active-low reset; all machines idle, no clearing pass needed.
// A result waiting on m_ready stalls the sequencer only at its last solenoid.
module solenoid_kick_sustain_controller (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  sks_pkg::sks_in_t                  s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output sks_pkg::sks_out_t                 m_data,
    input  logic                              cfg_wr_en,
    input  logic [sks_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sks_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    localparam int IW = sks_pkg::SOL_IDX_W;
    localparam int N  = sks_pkg::NUM_SOLENOIDS;

    logic        block_enable_reg;
    logic [7:0]  use_switch_mask_reg;
    logic [7:0]  auto_clear_mask_reg;
    logic [63:0] kick_times_ms_reg;
    logic [63:0] duty_settings_reg;
    logic [15:0] switch_thresh_us_reg;

    logic             busy_reg;
    logic [IW-1:0]    idx_reg;
    sks_pkg::sks_in_t item_reg;
    logic [7:0]       drive_reg, drive_next;
    logic [7:0]       valid_acc_reg, clr_acc_reg;
    logic [N-1:0]     entry_vld_reg;
    logic             rd_vld_reg;
    logic             fwd_hit_reg;
    sks_pkg::sks_entry_t fwd_data_reg;
    logic             m_valid_reg;
    sks_pkg::sks_out_t m_data_reg;

    logic          accept, last, out_free, adv;
    logic [IW-1:0] ram_raddr;
    logic          ram_we;
    logic [sks_pkg::ENTRY_W-1:0] ram_rdata;
    sks_pkg::sks_entry_t cur, rd_entry, nxt;
    sks_pkg::sks_ctl_t   ctl;
    sks_pkg::sks_flags_t flags;
    logic [4:0]    idx_ext;
    logic [2:0]    b;
    logic          in_port;
    logic [7:0]    sol_bit, valid_hit, clr_hit;

    assign last     = idx_reg == IW'(N - 1);
    assign out_free = !m_valid_reg || m_ready;
    assign adv      = busy_reg && (!last || out_free);
    assign s_ready  = !busy_reg || (last && out_free);
    assign accept   = s_valid && s_ready;

    always_comb begin
        priority if (accept) begin
            ram_raddr = '0;
        end else if (adv && !last) begin
            ram_raddr = idx_reg + 1'b1;
        end else begin
            ram_raddr = idx_reg;
        end
    end

    assign ram_we = adv && block_enable_reg;

    sks_ram #(
        .WIDTH (sks_pkg::ENTRY_W),
        .DEPTH (N)
    ) u_state_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (idx_reg),
        .wdata (nxt),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb begin
        rd_entry = fwd_hit_reg ? fwd_data_reg : sks_pkg::sks_entry_t'(ram_rdata);
        cur      = rd_entry;
        if (!rd_vld_reg) begin
            cur.phase = sks_pkg::PH_IDLE;
        end
    end

    assign idx_ext = 5'(idx_reg);
    assign b       = idx_ext[2:0];
    assign in_port = idx_ext < 5'(sks_pkg::NUM_PORT_SOL);
    assign sol_bit = in_port ? (8'h01 << b) : 8'h00;

    always_comb begin
        ctl.act        = in_port &&
                         ((use_switch_mask_reg[b] && !item_reg.switch_levels[sks_pkg::PORT_BIT_OF[b]])
                          || item_reg.proc_request[b]);
        ctl.kick_ms    = kick_times_ms_reg[{b, 3'b000} +: 8];
        ctl.duty       = duty_settings_reg[{b, 3'b000} +: 4];
        ctl.off_limit  = {duty_settings_reg[{b, 3'b100} +: 4], 4'h0};
        ctl.auto_clear = auto_clear_mask_reg[b];
    end

    sks_update u_update (
        .cur       (cur),
        .ctl       (ctl),
        .now_us    (item_reg.time_us),
        .thresh_us (switch_thresh_us_reg),
        .nxt       (nxt),
        .flags     (flags)
    );

    always_comb begin
        drive_next = drive_reg;
        valid_hit  = 8'h00;
        clr_hit    = 8'h00;
        if (block_enable_reg) begin
            if (flags.drive_set) begin
                drive_next = drive_reg | sol_bit;
            end else if (flags.drive_clr) begin
                drive_next = drive_reg & ~sol_bit;
            end
            valid_hit = flags.validated ? sol_bit : 8'h00;
            clr_hit   = flags.clear_req ? sol_bit : 8'h00;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            block_enable_reg     <= 1'b0;
            use_switch_mask_reg  <= 8'h00;
            auto_clear_mask_reg  <= 8'h00;
            kick_times_ms_reg    <= 64'h0;
            duty_settings_reg    <= 64'h0;
            switch_thresh_us_reg <= 16'h0;
            busy_reg             <= 1'b0;
            idx_reg              <= '0;
            drive_reg            <= 8'h00;
            valid_acc_reg        <= 8'h00;
            clr_acc_reg          <= 8'h00;
            entry_vld_reg        <= '0;
            rd_vld_reg           <= 1'b0;
            fwd_hit_reg          <= 1'b0;
            m_valid_reg          <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    sks_pkg::CFG_BLOCK_ENABLE:     block_enable_reg     <= cfg_wdata[0];
                    sks_pkg::CFG_USE_SWITCH_MASK:  use_switch_mask_reg  <= cfg_wdata[7:0];
                    sks_pkg::CFG_AUTO_CLEAR_MASK:  auto_clear_mask_reg  <= cfg_wdata[7:0];
                    sks_pkg::CFG_KICK_TIMES_MS:    kick_times_ms_reg    <= cfg_wdata;
                    sks_pkg::CFG_DUTY_SETTINGS:    duty_settings_reg    <= cfg_wdata;
                    sks_pkg::CFG_SWITCH_THRESH_US: switch_thresh_us_reg <= cfg_wdata[15:0];
                    default: begin
                    end
                endcase
            end

            if (accept) begin
                busy_reg      <= 1'b1;
                idx_reg       <= '0;
                valid_acc_reg <= 8'h00;
                clr_acc_reg   <= 8'h00;
            end else if (adv) begin
                if (last) begin
                    busy_reg <= 1'b0;
                end else begin
                    idx_reg <= idx_reg + 1'b1;
                end
                valid_acc_reg <= valid_acc_reg | valid_hit;
                clr_acc_reg   <= clr_acc_reg | clr_hit;
            end

            if (adv) begin
                drive_reg <= drive_next;
            end
            if (ram_we) begin
                entry_vld_reg[idx_reg] <= 1'b1;
            end

            rd_vld_reg  <= entry_vld_reg[ram_raddr] || (ram_we && idx_reg == ram_raddr);
            fwd_hit_reg <= ram_we && idx_reg == ram_raddr;

            if (adv && last) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg <= s_data;
        end
        fwd_data_reg <= nxt;
        if (adv && last) begin
            m_data_reg.drive_bits       <= drive_next;
            m_data_reg.valid_switch_set <= valid_acc_reg | valid_hit;
            m_data_reg.request_clear    <= clr_acc_reg | clr_hit;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> busy_reg && idx_reg == '0)
        else $error("sequencer did not restart at solenoid zero");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg && !adv |=> busy_reg && $stable(idx_reg) && $stable(drive_reg))
        else $error("sequencer moved while result slot was full");

    a_frozen_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        !block_enable_reg |-> !ram_we)
        else $error("state written while block disabled");

    a_last_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        adv && last && !accept |=> !busy_reg && m_valid_reg)
        else $error("last solenoid did not deliver a result");

endmodule

[rtl/sks_ram.sv]
// sks_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module sks_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/sks_update.sv]
// sks_update: next-state logic for one solenoid's machine, one entry per cycle.
// Depends on sks_pkg.
module sks_update (
    input  sks_pkg::sks_entry_t cur,
    input  sks_pkg::sks_ctl_t   ctl,
    input  logic [31:0]         now_us,
    input  logic [15:0]         thresh_us,
    output sks_pkg::sks_entry_t nxt,
    output sks_pkg::sks_flags_t flags
);
    logic [31:0] el_us;
    logic [17:0] kick_us;
    logic [4:0]  on_ms;
    logic [14:0] on_us;
    logic        kick_done;
    logic [7:0]  off_inc;

    // floor(el_us / 1000) >= k  <=>  el_us >= k * 1000
    assign el_us     = now_us - cur.start_us;
    assign kick_us   = 18'(ctl.kick_ms) * 18'(sks_pkg::US_PER_MS);
    assign on_ms     = 5'(sks_pkg::PWM_PERIOD_MS + 1) - {1'b0, ctl.duty};
    assign on_us     = 15'(on_ms) * 15'(sks_pkg::US_PER_MS);
    assign kick_done = el_us >= 32'(kick_us);
    assign off_inc   = cur.off_count + sks_pkg::OFF_STEP;

    always_comb begin
        nxt   = cur;
        flags = '0;
        unique case (cur.phase)
            sks_pkg::PH_IDLE: begin
                if (ctl.act) begin
                    nxt.start_us = now_us;
                    nxt.phase    = sks_pkg::PH_DEBOUNCE;
                end
            end
            sks_pkg::PH_DEBOUNCE: begin
                if (!ctl.act) begin
                    nxt.phase = sks_pkg::PH_IDLE;
                end else if (el_us >= 32'(thresh_us)) begin
                    nxt.phase       = sks_pkg::PH_KICK;
                    nxt.found_clear = 1'b0;
                    nxt.start_us    = now_us;
                    flags.validated = 1'b1;
                    flags.drive_set = 1'b1;
                    flags.clear_req = ctl.auto_clear;
                end
            end
            sks_pkg::PH_KICK: begin
                if (!ctl.act) begin
                    nxt.found_clear = 1'b1;
                end
                if (kick_done) begin
                    flags.drive_clr = 1'b1;
                    nxt.start_us    = now_us;
                    if (ctl.duty != 4'd0 && ctl.act) begin
                        nxt.phase = sks_pkg::PH_SUSTAIN;
                    end else begin
                        nxt.phase     = sks_pkg::PH_MIN_OFF;
                        nxt.off_count = 8'h00;
                    end
                end
            end
            sks_pkg::PH_SUSTAIN: begin
                if (ctl.act) begin
                    if (el_us >= sks_pkg::SUSTAIN_END_US) begin
                        flags.drive_clr = 1'b1;
                        nxt.start_us    = now_us;
                    end else if (el_us >= 32'(on_us)) begin
                        flags.drive_set = 1'b1;
                    end
                end else begin
                    flags.drive_clr = 1'b1;
                    nxt.phase       = sks_pkg::PH_IDLE;
                end
            end
            sks_pkg::PH_WAIT_CLEAR: begin
                if (!ctl.act) begin
                    nxt.phase = sks_pkg::PH_IDLE;
                end
            end
            sks_pkg::PH_MIN_OFF: begin
                if (!ctl.act) begin
                    nxt.found_clear = 1'b1;
                end
                if (kick_done) begin
                    nxt.off_count = off_inc;
                    if (off_inc >= ctl.off_limit) begin
                        nxt.phase = (cur.found_clear || !ctl.act) ? sks_pkg::PH_IDLE
                                                                  : sks_pkg::PH_WAIT_CLEAR;
                    end else begin
                        nxt.start_us = now_us;
                    end
                end
            end
            default: begin
            end
        endcase
    end

endmodule

[bench/testbench.sv]
`timescale 1ns / 100ps
// Testbench for solenoid_kick_sustain_controller: directed poll table, then random polls
// under several register settings; table rows with expected values are checked against
// them, others by an in-bench predictor. Depends on sks_pkg and the RTL top level only.
module testbench;

    localparam int          LIMIT_CYCLES   = 600000;
    localparam int          HOLD_AT_RESULT = 500;
    localparam int          HOLD_CYCLES    = 400;
    localparam int          NSOL           = 8;
    localparam logic [31:0] PWM_MS         = 32'd16;
    localparam logic [31:0] MS_US          = 32'd1000;
    localparam logic [7:0]  OFF_INC        = 8'h10;
    localparam int          SW_PORT [NSOL] = '{0, 1, 3, 2, 5, 4, 7, 6};

    typedef struct packed {
        logic        en;
        logic [7:0]  use_m;
        logic [7:0]  auto_m;
        logic [63:0] kick;
        logic [63:0] duty;
        logic [15:0] thresh;
    } cfg_set_t;

    typedef enum logic [1:0] {
        ROW_CFG,
        ROW_POLL,
        ROW_CHECKED
    } row_kind_t;

    typedef struct packed {
        row_kind_t          kind;
        cfg_set_t           cfg;
        sks_pkg::sks_in_t   poll;
        sks_pkg::sks_out_t  want;
    } dir_row_t;

    logic              aclk      = 1'b0;
    logic              aresetn   = 1'b0;
    logic              s_valid   = 1'b0;
    logic              s_ready;
    sks_pkg::sks_in_t  s_data    = '0;
    logic              m_valid;
    logic              m_ready   = 1'b0;
    sks_pkg::sks_out_t m_data;
    logic              cfg_wr_en = 1'b0;
    logic [sks_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [sks_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

    // predictor state and register copy
    cfg_set_t            regs_q;
    sks_pkg::sks_phase_t phase_q   [NSOL];
    logic [31:0]         start_q   [NSOL];
    logic [7:0]          offcnt_q  [NSOL];
    logic                fclear_q  [NSOL];
    logic [7:0]          drive_q;

    sks_pkg::sks_out_t poll_results_q [$];
    dir_row_t    dir_rows [$];
    int          mismatches = 0;
    int          taken      = 0;
    int          cycles     = 0;
    logic        send_quiet = 1'b0;
    logic        take_quiet = 1'b0;
    logic [31:0] t_now      = 32'hFFF0_0000;
    logic [7:0]  sw_hold    = '0;
    logic [7:0]  rq_hold    = '0;

    solenoid_kick_sustain_controller dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    function automatic sks_pkg::sks_out_t advance_solenoids(sks_pkg::sks_in_t p);
        sks_pkg::sks_out_t r;
        logic [7:0]  valid_b;
        logic [7:0]  clr_b;
        logic [31:0] el_us;
        logic [31:0] el_ms;
        logic [7:0]  kick;
        logic [7:0]  offlim;
        logic [3:0]  duty;
        logic        act;
        valid_b = '0;
        clr_b   = '0;
        if (regs_q.en) begin
            for (int i = 0; i < NSOL; i++) begin
                act    = (regs_q.use_m[i] && !p.switch_levels[SW_PORT[i]]) || p.proc_request[i];
                kick   = regs_q.kick[8*i +: 8];
                offlim = regs_q.duty[8*i +: 8] & 8'hF0;
                duty   = regs_q.duty[8*i +: 4];
                el_us  = p.time_us - start_q[i];
                el_ms  = el_us / MS_US;
                case (phase_q[i])
                    sks_pkg::PH_IDLE: begin
                        if (act) begin
                            start_q[i] = p.time_us;
                            phase_q[i] = sks_pkg::PH_DEBOUNCE;
                        end
                    end
                    sks_pkg::PH_DEBOUNCE: begin
                        if (!act) begin
                            phase_q[i] = sks_pkg::PH_IDLE;
                        end else if (el_us >= 32'(regs_q.thresh)) begin
                            phase_q[i]  = sks_pkg::PH_KICK;
                            valid_b[i]  = 1'b1;
                            fclear_q[i] = 1'b0;
                            drive_q[i]  = 1'b1;
                            start_q[i]  = p.time_us;
                            clr_b[i]    = regs_q.auto_m[i];
                        end
                    end
                    sks_pkg::PH_KICK: begin
                        if (!act) fclear_q[i] = 1'b1;
                        if (el_ms >= 32'(kick)) begin
                            drive_q[i] = 1'b0;
                            if (duty != 4'd0 && act) begin
                                phase_q[i] = sks_pkg::PH_SUSTAIN;
                            end else begin
                                phase_q[i]  = sks_pkg::PH_MIN_OFF;
                                offcnt_q[i] = '0;
                            end
                            start_q[i] = p.time_us;
                        end
                    end
                    sks_pkg::PH_SUSTAIN: begin
                        if (act) begin
                            if (el_ms > PWM_MS) begin
                                drive_q[i] = 1'b0;
                                start_q[i] = p.time_us;
                            end else if (el_ms > PWM_MS - 32'(duty)) begin
                                drive_q[i] = 1'b1;
                            end
                        end else begin
                            drive_q[i] = 1'b0;
                            phase_q[i] = sks_pkg::PH_IDLE;
                        end
                    end
                    sks_pkg::PH_WAIT_CLEAR: begin
                        if (!act) phase_q[i] = sks_pkg::PH_IDLE;
                    end
                    sks_pkg::PH_MIN_OFF: begin
                        if (!act) fclear_q[i] = 1'b1;
                        if (el_ms >= 32'(kick)) begin
                            offcnt_q[i] = offcnt_q[i] + OFF_INC;
                            if (offcnt_q[i] >= offlim) begin
                                phase_q[i] = fclear_q[i] ? sks_pkg::PH_IDLE
                                                         : sks_pkg::PH_WAIT_CLEAR;
                            end else begin
                                start_q[i] = p.time_us;
                            end
                        end
                    end
                    default: ;
                endcase
            end
        end
        r.drive_bits       = drive_q;
        r.valid_switch_set = valid_b;
        r.request_clear    = clr_b;
        return r;
    endfunction

    function automatic cfg_set_t make_cfg(logic en, logic [7:0] use_m, logic [7:0] auto_m,
                                          logic [63:0] kick, logic [63:0] duty,
                                          logic [15:0] thresh);
        cfg_set_t c;
        c.en     = en;
        c.use_m  = use_m;
        c.auto_m = auto_m;
        c.kick   = kick;
        c.duty   = duty;
        c.thresh = thresh;
        return c;
    endfunction

    function automatic cfg_set_t random_cfg();
        cfg_set_t c;
        c.en     = 1'b1;
        c.use_m  = 8'($urandom);
        c.auto_m = 8'($urandom);
        for (int b = 0; b < NSOL; b++) begin
            c.kick[8*b +: 8] = 8'($urandom_range(0, 12));
            c.duty[8*b +: 8] = 8'($urandom);
        end
        c.thresh = 16'($urandom_range(0, 4000));
        return c;
    endfunction

    function automatic dir_row_t cfg_row(cfg_set_t c);
        dir_row_t r;
        r      = '0;
        r.kind = ROW_CFG;
        r.cfg  = c;
        return r;
    endfunction

    function automatic dir_row_t poll_row(logic [31:0] t, logic [7:0] lv, logic [7:0] rq);
        dir_row_t r;
        r                    = '0;
        r.kind               = ROW_POLL;
        r.poll.time_us       = t;
        r.poll.switch_levels = lv;
        r.poll.proc_request  = rq;
        return r;
    endfunction

    function automatic dir_row_t chk_row(logic [31:0] t, logic [7:0] lv, logic [7:0] rq,
                                         logic [7:0] drv, logic [7:0] vld, logic [7:0] clr);
        dir_row_t r;
        r                         = poll_row(t, lv, rq);
        r.kind                    = ROW_CHECKED;
        r.want.drive_bits         = drv;
        r.want.valid_switch_set   = vld;
        r.want.request_clear      = clr;
        return r;
    endfunction

    // held triggers toggle slowly so most polls continue a well-formed press
    function automatic sks_pkg::sks_in_t next_poll();
        sks_pkg::sks_in_t p;
        int               pick;
        pick = $urandom_range(0, 99);
        if (pick < 70) t_now = t_now + $urandom_range(0, 2000);
        else if (pick < 95) t_now = t_now + $urandom_range(0, 20000);
        else t_now = t_now + $urandom;
        for (int i = 0; i < NSOL; i++) begin
            if ($urandom_range(0, 11) == 0) sw_hold[i] = ~sw_hold[i];
            if ($urandom_range(0, 15) == 0) rq_hold[i] = ~rq_hold[i];
            p.switch_levels[SW_PORT[i]] = ~sw_hold[i];
        end
        if ($urandom_range(0, 15) == 0) p.switch_levels = 8'($urandom);
        p.proc_request = ($urandom_range(0, 31) == 0) ? 8'($urandom) : rq_hold;
        p.time_us      = t_now;
        return p;
    endfunction

    task automatic flag_mismatch(string what, logic [7:0] got, logic [7:0] want);
        $display("mismatch %s at result %0d: got %02h want %02h", what, taken, got, want);
        mismatches++;
    endtask

    task automatic write_reg(logic [sks_pkg::CFG_IDX_W-1:0] idx,
                             logic [sks_pkg::CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
    endtask

    task automatic apply_cfg(cfg_set_t c);
        s_valid <= 1'b0;
        while (poll_results_q.size() != 0) @(posedge aclk);
        repeat (2 * NSOL) @(posedge aclk);
        write_reg(sks_pkg::CFG_BLOCK_ENABLE, 64'(c.en));
        write_reg(sks_pkg::CFG_USE_SWITCH_MASK, 64'(c.use_m));
        write_reg(sks_pkg::CFG_AUTO_CLEAR_MASK, 64'(c.auto_m));
        write_reg(sks_pkg::CFG_KICK_TIMES_MS, c.kick);
        write_reg(sks_pkg::CFG_DUTY_SETTINGS, c.duty);
        write_reg(sks_pkg::CFG_SWITCH_THRESH_US, 64'(c.thresh));
        cfg_wr_en <= 1'b0;
        regs_q = c;
    endtask

    task automatic send_poll(sks_pkg::sks_in_t p, logic typed, sks_pkg::sks_out_t want);
        int                gap;
        sks_pkg::sks_out_t pred;
        gap = send_quiet ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= p;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pred = advance_solenoids(p);
        poll_results_q.push_back(typed ? want : pred);
    endtask

    initial begin : result_side
        int                stall;
        sks_pkg::sks_out_t got;
        sks_pkg::sks_out_t want;
        wait (aresetn === 1'b1);
        forever begin
            if (taken % 48 == 0) take_quiet = ($urandom_range(0, 3) == 0);
            stall = take_quiet ? 0 : $urandom_range(0, 16);
            if (taken == HOLD_AT_RESULT) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            got = m_data;
            if (poll_results_q.size() == 0) begin
                flag_mismatch("unexpected result", got.drive_bits, 8'h00);
            end else begin
                want = poll_results_q.pop_front();
                if (got.drive_bits !== want.drive_bits)
                    flag_mismatch("drive_bits", got.drive_bits, want.drive_bits);
                if (got.valid_switch_set !== want.valid_switch_set)
                    flag_mismatch("valid_switch_set", got.valid_switch_set,
                                  want.valid_switch_set);
                if (got.request_clear !== want.request_clear)
                    flag_mismatch("request_clear", got.request_clear, want.request_clear);
            end
            taken++;
        end
    end

    initial begin : poll_side
        cfg_set_t c;
        cfg_set_t base;
        int       n;
        regs_q  = '0;
        drive_q = '0;
        for (int i = 0; i < NSOL; i++) begin
            phase_q[i]  = sks_pkg::PH_IDLE;
            start_q[i]  = '0;
            offcnt_q[i] = '0;
            fclear_q[i] = 1'b0;
        end
        base = make_cfg(1'b1, 8'hFF, 8'h0F, 64'h0906_0507_0102_0304,
                        64'h8F3C_0A55_1020_77F4, 16'd100);

        // disabled after reset
        dir_rows.push_back(chk_row(32'h0000_0000, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h00));
        dir_rows.push_back(chk_row(32'hFFFF_FFFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00));
        dir_rows.push_back(cfg_row(base));
        // request kick, sustain PWM, release
        dir_rows.push_back(chk_row(32'd1000, 8'hFF, 8'h01, 8'h00, 8'h00, 8'h00));
        dir_rows.push_back(chk_row(32'd1100, 8'hFF, 8'h01, 8'h01, 8'h01, 8'h01));
        dir_rows.push_back(poll_row(32'd3000, 8'hFF, 8'h01));
        dir_rows.push_back(poll_row(32'd5200, 8'hFF, 8'h01));
        dir_rows.push_back(poll_row(32'd15000, 8'hFF, 8'h01));
        dir_rows.push_back(poll_row(32'd18300, 8'hFF, 8'h01));
        dir_rows.push_back(poll_row(32'd22300, 8'hFF, 8'h01));
        dir_rows.push_back(poll_row(32'd23000, 8'hFF, 8'h00));
        // switch trigger, short press, then min off steps
        dir_rows.push_back(poll_row(32'd30000, 8'hF7, 8'h00));
        dir_rows.push_back(poll_row(32'd30050, 8'hF7, 8'h00));
        dir_rows.push_back(poll_row(32'd30060, 8'hFF, 8'h00));
        dir_rows.push_back(poll_row(32'd31000, 8'hF7, 8'h00));
        dir_rows.push_back(poll_row(32'd31200, 8'hF7, 8'h00));
        dir_rows.push_back(poll_row(32'd31300, 8'hFF, 8'h00));
        dir_rows.push_back(poll_row(32'd33500, 8'hFF, 8'h00));
        dir_rows.push_back(poll_row(32'd36000, 8'hFF, 8'h00));
        dir_rows.push_back(poll_row(32'd38100, 8'hFF, 8'h00));
        // freeze mid kick, then wait-for-clear
        dir_rows.push_back(poll_row(32'd40000, 8'hFF, 8'h08));
        dir_rows.push_back(poll_row(32'd40200, 8'hFF, 8'h08));
        c    = base;
        c.en = 1'b0;
        dir_rows.push_back(cfg_row(c));
        dir_rows.push_back(chk_row(32'd41000, 8'h00, 8'hFF, 8'h08, 8'h00, 8'h00));
        dir_rows.push_back(cfg_row(base));
        dir_rows.push_back(poll_row(32'd42000, 8'hFF, 8'h08));
        dir_rows.push_back(poll_row(32'd43100, 8'hFF, 8'h08));
        dir_rows.push_back(poll_row(32'd44000, 8'hFF, 8'h00));
        // timestamp wrap during debounce
        dir_rows.push_back(poll_row(32'hFFFF_FF00, 8'hFF, 8'h10));
        dir_rows.push_back(poll_row(32'h0000_0100, 8'hFF, 8'h10));

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[r]) begin
            if (dir_rows[r].kind == ROW_CFG)
                apply_cfg(dir_rows[r].cfg);
            else
                send_poll(dir_rows[r].poll, dir_rows[r].kind == ROW_CHECKED, dir_rows[r].want);
        end

        for (int ph = 0; ph < 7; ph++) begin
            case (ph)
                0: c = make_cfg(1'b1, 8'hFF, 8'h00, '0, '0, '0);
                1: c = make_cfg(1'b1, 8'hFF, 8'hFF, '1, '1, '1);
                2: begin
                    c    = random_cfg();
                    c.en = 1'b0;
                end
                default: c = random_cfg();
            endcase
            apply_cfg(c);
            n = (ph == 2) ? 40 : 220;
            for (int k = 0; k < n; k++) begin
                if (k % 48 == 0) send_quiet = ($urandom_range(0, 3) == 0);
                send_poll(next_poll(), 1'b0, '0);
            end
        end

        s_valid <= 1'b0;
        while (poll_results_q.size() != 0) @(posedge aclk);
        repeat (4 * NSOL) @(posedge aclk);
        if (mismatches == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule

[filelist.f]
rtl/sks_pkg.sv
rtl/sks_ram.sv
rtl/sks_update.sv
rtl/solenoid_kick_sustain_controller.sv
bench/testbench.sv
